FILE: rtl/u16u8_pkg.sv
package u16u8_pkg;

  localparam int unsigned UnitW  = 16;
  localparam int unsigned CpW    = 21;
  localparam int unsigned SurrW  = 10;
  localparam int unsigned QDepth = 2;

  localparam logic [UnitW-1:0] SurrLo     = 16'hD800;
  localparam logic [UnitW-1:0] SurrHi     = 16'hDFFF;
  localparam logic [CpW-1:0]   SuppOffset = 21'h10000;

  // Number of UTF-8 bytes minus one.
  typedef enum logic [1:0] {
    LEN_1 = 2'd0,
    LEN_2 = 2'd1,
    LEN_3 = 2'd2,
    LEN_4 = 2'd3
  } len_t;

  typedef struct packed {
    logic [CpW-1:0] cp;
    len_t           len;
    logic           last;
  } cp_item_t;

  function automatic len_t utf8_len(input logic [CpW-1:0] cp);
    len_t l;
    if (cp[20:16] != 5'd0) begin
      l = LEN_4;
    end else if (cp[15:11] != 5'd0) begin
      l = LEN_3;
    end else if (cp[10:7] != 4'd0) begin
      l = LEN_2;
    end else begin
      l = LEN_1;
    end
    return l;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [CpW-1:0] cp, input len_t len,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (len)
      LEN_1: b = {1'b0, cp[6:0]};
      LEN_2: begin
        case (idx)
          2'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      LEN_3: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      LEN_4: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/u16u8_front.sv
module u16u8_front
  import u16u8_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [UnitW-1:0] in_code_unit,
  input  logic             in_last_unit,
  input  logic             q_full,
  output logic             q_push,
  output cp_item_t         q_item
);

  logic             half_pending_r, half_pending_nxt;
  logic [SurrW-1:0] pending_bits_r, pending_bits_nxt;
  logic             accept;
  logic             is_surr;
  logic [CpW-1:0]   cp;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_surr  = (in_code_unit >= SurrLo) && (in_code_unit <= SurrHi);

  // A held first half always pairs with the next unit, whatever its value.
  assign cp = half_pending_r
            ? ({1'b0, pending_bits_r, in_code_unit[SurrW-1:0]} + SuppOffset)
            : {{(CpW-UnitW){1'b0}}, in_code_unit};

  assign q_item.cp   = cp;
  assign q_item.len  = utf8_len(cp);
  assign q_item.last = in_last_unit;
  assign q_push      = accept && (half_pending_r || !is_surr || in_last_unit);

  always_comb begin
    half_pending_nxt = half_pending_r;
    pending_bits_nxt = pending_bits_r;
    if (accept) begin
      if (half_pending_r) begin
        half_pending_nxt = 1'b0;
        pending_bits_nxt = '0;
      end else if (is_surr && !in_last_unit) begin
        half_pending_nxt = 1'b1;
        pending_bits_nxt = in_code_unit[SurrW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_pending_r <= 1'b0;
      pending_bits_r <= '0;
    end else begin
      half_pending_r <= half_pending_nxt;
      pending_bits_r <= pending_bits_nxt;
    end
  end

endmodule

FILE: rtl/u16u8_queue.sv
module u16u8_queue
  import u16u8_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  cp_item_t push_item,
  input  logic     pop,
  output cp_item_t head,
  output logic     full,
  output logic     empty
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  cp_item_t            mem_r [QDepth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]       count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == (PtrW+1)'(QDepth));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/u16u8_back.sv
module u16u8_back
  import u16u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cp_item_t   q_head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic       out_char_end,
  output logic       out_string_end
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       char_end_r, char_end_nxt;
  logic       string_end_r, string_end_nxt;
  logic       load;
  logic       final_byte;

  // The output register takes a new byte when it is empty or its byte transfers.
  assign load       = !q_empty && (!out_valid_r || !out_stall);
  assign final_byte = (idx_r == 2'(q_head.len));
  assign q_pop      = load && final_byte;

  always_comb begin
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r;
    byte_nxt       = byte_r;
    char_end_nxt   = char_end_r;
    string_end_nxt = string_end_r;
    if (load) begin
      idx_nxt        = final_byte ? 2'd0 : idx_r + 2'd1;
      out_valid_nxt  = 1'b1;
      byte_nxt       = utf8_byte(q_head.cp, q_head.len, idx_r);
      char_end_nxt   = final_byte;
      string_end_nxt = final_byte && q_head.last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r       <= byte_nxt;
    char_end_r   <= char_end_nxt;
    string_end_r <= string_end_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_out_byte   = byte_r;
  assign out_char_end   = char_end_r;
  assign out_string_end = string_end_r;

endmodule

FILE: rtl/utf16_to_utf8_encoder.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall   in_code_unit[15:0], in_last_unit
// out_     output     out_valid / out_stall out_out_byte[7:0], out_char_end, out_string_end
//
// Each code point leaves as 1 to 4 bytes, one byte per cycle from the output
// register while out_stall is low; a leading surrogate half yields no byte.
// The byte serializer sets the rate; a two-entry queue lets units keep arriving.
// Reset (rst_n, synchronous) empties the queue and drops any held surrogate half.
// A stall on the output side holds the byte; the input stalls only when the queue is full.
module utf16_to_utf8_encoder
  import u16u8_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [UnitW-1:0] in_code_unit,
  input  logic             in_last_unit,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_out_byte,
  output logic             out_char_end,
  output logic             out_string_end
);

  cp_item_t push_item;
  cp_item_t head;
  logic     q_push, q_pop, q_full, q_empty;

  u16u8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_code_unit (in_code_unit),
    .in_last_unit (in_last_unit),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  u16u8_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  u16u8_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_out_byte   (out_out_byte),
    .out_char_end   (out_char_end),
    .out_string_end (out_string_end)
  );

endmodule

FILE: test/tb_utf16_to_utf8_encoder.sv
module tb_utf16_to_utf8_encoder;
  import u16u8_pkg::*;

  localparam int unsigned NDir      = 25;
  localparam int unsigned RandUnits = 255;

  typedef struct packed {
    logic [7:0] data;
    logic       char_end;
    logic       string_end;
  } utf8_out_t;

  // A row with typed set carries its bytes, first byte in the top octet.
  typedef struct packed {
    logic [15:0] unit;
    logic        last;
    logic        typed;
    logic [2:0]  nb;
    logic [31:0] seq;
  } dir_row_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC,
    RX_HEAVY
  } rx_mode_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [UnitW-1:0] in_code_unit;
  logic             in_last_unit;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_out_byte;
  logic             out_char_end;
  logic             out_string_end;

  utf8_out_t   expected_bytes[$];
  logic        hi_held;
  logic [9:0]  hi_bits;
  int unsigned n_err;
  int unsigned n_units;
  int unsigned n_bytes;
  int unsigned n_strings;
  int unsigned burst_left;

  dir_row_t dir_tab [NDir] = '{
    '{16'h0000, 1'b0, 1'b1, 3'd1, 32'h0000_0000},
    '{16'h007F, 1'b0, 1'b1, 3'd1, 32'h7F00_0000},
    '{16'h0080, 1'b0, 1'b1, 3'd2, 32'hC280_0000},
    '{16'h07FF, 1'b0, 1'b1, 3'd2, 32'hDFBF_0000},
    '{16'h0800, 1'b0, 1'b1, 3'd3, 32'hE0A0_8000},
    '{16'hFFFF, 1'b1, 1'b1, 3'd3, 32'hEFBF_BF00},
    '{16'hD800, 1'b0, 1'b1, 3'd0, 32'h0000_0000},
    '{16'hDC00, 1'b0, 1'b1, 3'd4, 32'hF090_8080},
    '{16'hDBFF, 1'b0, 1'b1, 3'd0, 32'h0000_0000},
    '{16'hDFFF, 1'b1, 1'b1, 3'd4, 32'hF48F_BFBF},
    '{16'hD7FF, 1'b1, 1'b1, 3'd3, 32'hED9F_BF00},
    '{16'hD800, 1'b1, 1'b1, 3'd3, 32'hEDA0_8000},
    '{16'hDFFF, 1'b1, 1'b1, 3'd3, 32'hEDBF_BF00},
    '{16'hDC00, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{16'hD800, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{16'hD83D, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{16'hDE00, 1'b1, 1'b0, 3'd0, 32'h0000_0000},
    '{16'hD812, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{16'h0041, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{16'hFFFE, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{16'h1234, 1'b1, 1'b0, 3'd0, 32'h0000_0000},
    '{16'hAAAA, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{16'h5555, 1'b1, 1'b0, 3'd0, 32'h0000_0000},
    '{16'hE000, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{16'h0100, 1'b1, 1'b0, 3'd0, 32'h0000_0000}
  };

  utf16_to_utf8_encoder u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_code_unit   (in_code_unit),
    .in_last_unit   (in_last_unit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_out_byte   (out_out_byte),
    .out_char_end   (out_char_end),
    .out_string_end (out_string_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Computes the UTF-8 bytes that one code unit causes and updates the held half.
  function automatic void transcode_unit(input logic [15:0] unit, input logic last,
                                         output int unsigned nb, output logic [31:0] seq);
    logic [20:0] cp;
    len_t        len;
    nb  = 0;
    seq = '0;
    if (hi_held) begin
      cp      = {1'b0, hi_bits, unit[9:0]} + 21'h10000;
      hi_held = 1'b0;
      hi_bits = '0;
    end else if (unit >= SurrLo && unit <= SurrHi && !last) begin
      hi_held = 1'b1;
      hi_bits = unit[9:0];
      return;
    end else begin
      cp = {5'd0, unit};
    end
    if (cp < 21'h80) begin
      len = LEN_1;
    end else if (cp < 21'h800) begin
      len = LEN_2;
    end else if (cp < 21'h10000) begin
      len = LEN_3;
    end else begin
      len = LEN_4;
    end
    case (len)
      LEN_1: seq = {1'b0, cp[6:0], 24'h0};
      LEN_2: seq = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
      LEN_3: seq = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
      default: begin
        seq = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
      end
    endcase
    nb = 32'(len) + 32'd1;
  endfunction

  // Presents one unit, waits for its transfer and queues the bytes it should produce.
  task automatic send_code_unit(input logic [15:0] unit, input logic last,
                                input logic typed, input int unsigned typed_nb,
                                input logic [31:0] typed_seq);
    int unsigned gap;
    int unsigned nb;
    logic [31:0] seq;
    utf8_out_t   o;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left   = burst_left - 1;
    in_valid     <= 1'b1;
    in_code_unit <= unit;
    in_last_unit <= last;
    do @(posedge clk); while (in_stall);
    n_units = n_units + 1;
    transcode_unit(unit, last, nb, seq);
    if (typed) begin
      nb  = typed_nb;
      seq = typed_seq;
    end
    for (int k = 0; k < nb; k++) begin
      o.data       = seq[31 - 8 * k -: 8];
      o.char_end   = (k == nb - 1);
      o.string_end = (k == nb - 1) && last;
      expected_bytes.push_back(o);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    utf8_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_bytes = n_bytes + 1;
      if (out_string_end) n_strings = n_strings + 1;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte %h char_end=%b string_end=%b", $time,
                 out_out_byte, out_char_end, out_string_end);
        n_err = n_err + 1;
      end else begin
        want = expected_bytes.pop_front();
        if (out_out_byte !== want.data) begin
          $display("%0t: out_byte expected %h, got %h", $time, want.data, out_out_byte);
          n_err = n_err + 1;
        end
        if (out_char_end !== want.char_end) begin
          $display("%0t: char_end expected %b, got %b", $time, want.char_end,
                   out_char_end);
          n_err = n_err + 1;
        end
        if (out_string_end !== want.string_end) begin
          $display("%0t: string_end expected %b, got %b", $time, want.string_end,
                   out_string_end);
          n_err = n_err + 1;
        end
      end
    end
  end

  // The receiver switches between free running, random, periodic and heavy stalls.
  rx_mode_t    rx_mode = RX_FREE;
  int unsigned rx_left = 0;
  int unsigned rx_cyc  = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 96);
    end else begin
      rx_left = rx_left - 1;
    end
    rx_cyc = rx_cyc + 1;
    case (rx_mode)
      RX_FREE:     out_stall <= 1'b0;
      RX_RANDOM:   out_stall <= ($urandom_range(0, 9) < 4);
      RX_PERIODIC: out_stall <= (rx_cyc % 3 == 0);
      default:     out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  initial begin
    #2000000;
    $display("tb_utf16_to_utf8_encoder: errors");
    $finish;
  end

  initial begin
    int unsigned pick;
    logic        is_end;
    logic [15:0] u;
    logic        pressed;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_code_unit = '0;
    in_last_unit = 1'b0;
    out_stall    = 1'b0;
    hi_held      = 1'b0;
    hi_bits      = '0;
    n_err        = 0;
    n_units      = 0;
    n_bytes      = 0;
    n_strings    = 0;
    burst_left   = 0;
    pressed      = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NDir; i++) begin
      send_code_unit(dir_tab[i].unit, dir_tab[i].last, dir_tab[i].typed,
                     32'(dir_tab[i].nb), dir_tab[i].seq);
    end
    drain_results();

    // Mostly well-formed strings; the rest is raw units, which may pair a held half
    // with whatever unit follows it or end a string on a lone surrogate.
    while (n_units < NDir + RandUnits) begin
      for (int c = $urandom_range(1, 8); c > 0; c--) begin
        is_end = (c == 1);
        pick   = $urandom_range(0, 99);
        if (pick < 25) begin
          send_code_unit(16'($urandom_range(0, 16'h7F)), is_end, 1'b0, 0, '0);
        end else if (pick < 45) begin
          send_code_unit(16'($urandom_range(16'h80, 16'h7FF)), is_end, 1'b0, 0, '0);
        end else if (pick < 65) begin
          u = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(16'h800, 16'hD7FF))
                                           : 16'($urandom_range(16'hE000, 16'hFFFF));
          send_code_unit(u, is_end, 1'b0, 0, '0);
        end else if (pick < 85) begin
          send_code_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0, 1'b0, 0, '0);
          send_code_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), is_end, 1'b0, 0, '0);
        end else begin
          send_code_unit(16'($urandom), is_end | ($urandom_range(0, 3) == 0),
                         1'b0, 0, '0);
        end
      end
      if (!pressed && n_units > NDir + RandUnits / 2) begin
        drain_results();
        pressed = 1'b1;
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("Sent %0d UTF-16 code units in directed and random strings under input gaps",
             n_units);
    $display("and output stalls; checked %0d UTF-8 bytes ending %0d strings.", n_bytes,
             n_strings);
    if (n_err == 0) begin
      $display("tb_utf16_to_utf8_encoder: clean");
    end else begin
      $display("tb_utf16_to_utf8_encoder: errors");
    end
    $finish;
  end

endmodule
